/* rtl/assert_macros.svh */
// Assertion macros used by the controller of the DER signature unit.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`endif

/* rtl/dsig_pkg.sv */
// Types and constants of the DER signature unit.
// No dependencies.
`default_nettype none
package dsig_pkg;
    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] LONG_FORM    = 8'h80;

    localparam logic [3:0] PH_SEQ_TAG  = 4'd0;
    localparam logic [3:0] PH_SEQ_LEN  = 4'd1;
    localparam logic [3:0] PH_SEQ_SKIP = 4'd2;
    localparam logic [3:0] PH_R_TAG    = 4'd3;
    localparam logic [3:0] PH_R_LEN    = 4'd4;
    localparam logic [3:0] PH_R_LENX   = 4'd5;
    localparam logic [3:0] PH_R_VAL    = 4'd6;
    localparam logic [3:0] PH_S_TAG    = 4'd7;
    localparam logic [3:0] PH_S_LEN    = 4'd8;
    localparam logic [3:0] PH_S_LENX   = 4'd9;
    localparam logic [3:0] PH_S_VAL    = 4'd10;
    localparam logic [3:0] PH_DONE     = 4'd11;

    typedef struct packed {
        logic take;      // parse one byte
        logic clear;     // return parse state to reset
        logic emit;      // drive result for current index
        logic [6:0] idx; // result index
    } dsig_cmd_t;

    typedef struct packed {
        logic ok;        // parse ended in done with no failure
        logic overflow;
    } dsig_sts_t;
endpackage
`default_nettype wire

/* rtl/dsig_datapath.sv */
// Parse registers, value stores and output byte selection.
// Depends on dsig_pkg.
`default_nettype none
module dsig_datapath #(
    parameter int MAX_SCALAR_BYTES = 32,
    parameter int LENGTH_BITS      = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        sig_byte,
    input  wire dsig_pkg::dsig_cmd_t cmd,
    input  wire logic [6:0]        q,
    output dsig_pkg::dsig_sts_t    sts,
    output logic [7:0]             out_byte
);
    localparam int CW = $clog2(MAX_SCALAR_BYTES + 2);
    localparam int AW = (MAX_SCALAR_BYTES > 1) ? $clog2(MAX_SCALAR_BYTES) : 1;

    logic [3:0]             phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic [6:0]             lbl_reg, lbl_next;
    logic [7:0]             r_st_reg [MAX_SCALAR_BYTES];
    logic [7:0]             s_st_reg [MAX_SCALAR_BYTES];
    logic [CW-1:0]          rc_reg, rc_next, sc_reg, sc_next;
    logic                   strip_reg, strip_next, fail_reg, fail_next;
    logic                   push_r, push_s;
    logic [LENGTH_BITS+7:0] acc;
    logic                   second;
    logic [6:0]             j, pos;
    logic [CW-1:0]          cnt;
    logic [7:0]             sel;

    always_comb begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        lbl_next   = lbl_reg;
        rc_next    = rc_reg;
        sc_next    = sc_reg;
        strip_next = strip_reg;
        fail_next  = fail_reg;
        push_r     = 1'b0;
        push_s     = 1'b0;
        acc        = {rem_reg, sig_byte};
        if (cmd.clear) begin
            phase_next = dsig_pkg::PH_SEQ_TAG;
            rem_next   = '0;
            lbl_next   = '0;
            rc_next    = '0;
            sc_next    = '0;
            strip_next = 1'b1;
            fail_next  = 1'b0;
        end else if (cmd.take && !fail_reg && phase_reg != dsig_pkg::PH_DONE) begin
            case (phase_reg)
                dsig_pkg::PH_SEQ_TAG: begin
                    if (sig_byte != dsig_pkg::TAG_SEQUENCE) fail_next = 1'b1;
                    else phase_next = dsig_pkg::PH_SEQ_LEN;
                end
                dsig_pkg::PH_SEQ_LEN: begin
                    if (sig_byte[7] && sig_byte[6:0] != 7'd0) begin
                        lbl_next   = sig_byte[6:0];
                        phase_next = dsig_pkg::PH_SEQ_SKIP;
                    end else begin
                        phase_next = dsig_pkg::PH_R_TAG;
                    end
                end
                dsig_pkg::PH_SEQ_SKIP: begin
                    lbl_next = lbl_reg - 7'd1;
                    if (lbl_reg == 7'd1) phase_next = dsig_pkg::PH_R_TAG;
                end
                dsig_pkg::PH_R_TAG, dsig_pkg::PH_S_TAG: begin
                    if (sig_byte != dsig_pkg::TAG_INTEGER) fail_next = 1'b1;
                    else phase_next = phase_reg + 4'd1;
                end
                dsig_pkg::PH_R_LEN, dsig_pkg::PH_S_LEN: begin
                    if (sig_byte[7]) begin
                        rem_next = '0;
                        lbl_next = sig_byte[6:0];
                        if (sig_byte[6:0] == 7'd0) begin
                            strip_next = 1'b1;
                            phase_next = phase_reg + 4'd3;
                        end else begin
                            phase_next = phase_reg + 4'd1;
                        end
                    end else begin
                        rem_next   = LENGTH_BITS'(sig_byte);
                        strip_next = 1'b1;
                        phase_next = (sig_byte == 8'd0) ? phase_reg + 4'd3
                                                        : phase_reg + 4'd2;
                    end
                end
                dsig_pkg::PH_R_LENX, dsig_pkg::PH_S_LENX: begin
                    if (rem_reg != '0 || sig_byte != 8'd0) begin
                        if (acc[LENGTH_BITS+7:LENGTH_BITS] != 8'd0) fail_next = 1'b1;
                    end
                    if (!((rem_reg != '0 || sig_byte != 8'd0)
                          && acc[LENGTH_BITS+7:LENGTH_BITS] != 8'd0)) begin
                        rem_next = acc[LENGTH_BITS-1:0];
                        lbl_next = lbl_reg - 7'd1;
                        if (lbl_reg == 7'd1) begin
                            strip_next = 1'b1;
                            phase_next = (acc[LENGTH_BITS-1:0] == '0) ? phase_reg + 4'd2
                                                                      : phase_reg + 4'd1;
                        end
                    end
                end
                dsig_pkg::PH_R_VAL, dsig_pkg::PH_S_VAL: begin
                    rem_next = rem_reg - LENGTH_BITS'(1);
                    if (!(strip_reg && sig_byte == 8'd0)) begin
                        strip_next = 1'b0;
                        if (phase_reg == dsig_pkg::PH_R_VAL) begin
                            push_r = 1'b1;
                            if (rc_reg <= CW'(MAX_SCALAR_BYTES)) rc_next = rc_reg + CW'(1);
                        end else begin
                            push_s = 1'b1;
                            if (sc_reg <= CW'(MAX_SCALAR_BYTES)) sc_next = sc_reg + CW'(1);
                        end
                    end
                    if (rem_reg == LENGTH_BITS'(1)) phase_next = phase_reg + 4'd1;
                end
                default: fail_next = 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= dsig_pkg::PH_SEQ_TAG;
            rem_reg   <= '0;
            lbl_reg   <= '0;
            rc_reg    <= '0;
            sc_reg    <= '0;
            strip_reg <= 1'b1;
            fail_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            lbl_reg   <= lbl_next;
            rc_reg    <= rc_next;
            sc_reg    <= sc_next;
            strip_reg <= strip_next;
            fail_reg  <= fail_next;
        end
    end

    // stores are masked by count, so no reset is needed
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_SCALAR_BYTES - 1; i++) begin
            if (push_r) r_st_reg[i] <= r_st_reg[i+1];
            if (push_s) s_st_reg[i] <= s_st_reg[i+1];
        end
        if (push_r) r_st_reg[MAX_SCALAR_BYTES-1] <= sig_byte;
        if (push_s) s_st_reg[MAX_SCALAR_BYTES-1] <= sig_byte;
    end

    assign sts.ok       = !fail_reg && phase_reg == dsig_pkg::PH_DONE;
    assign sts.overflow = (rc_reg > CW'(q)) || (sc_reg > CW'(q));

    always_comb begin
        second = cmd.idx >= q;
        j      = second ? cmd.idx - q : cmd.idx;
        pos    = q - 7'd1 - j;
        cnt    = second ? sc_reg : rc_reg;
        sel    = second ? s_st_reg[AW'(MAX_SCALAR_BYTES - 1 - int'(pos))]
                        : r_st_reg[AW'(MAX_SCALAR_BYTES - 1 - int'(pos))];
        out_byte = (!sts.overflow && {1'b0, pos} < 8'(cnt)) ? sel : 8'd0;
    end
endmodule
`default_nettype wire

/* rtl/dsig_ctrl.sv */
// Controller: accepts bytes, sequences the result burst.
// Depends on dsig_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module dsig_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_last_byte,
    output logic                     s_ready,
    input  wire logic                m_ready,
    output logic                     m_valid,
    output logic                     m_status,
    output logic                     m_last_out,
    input  wire logic [6:0]          q,
    input  wire dsig_pkg::dsig_sts_t sts,
    output dsig_pkg::dsig_cmd_t      cmd
);
    localparam logic [1:0] ST_IN   = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [6:0] idx_reg, idx_next;
    logic [6:0] n;

    assign n = {q[5:0], 1'b0};
    assign s_ready = state_reg == ST_IN;
    assign m_valid = state_reg == ST_OUT || state_reg == ST_BAD;
    assign m_status = state_reg == ST_BAD;
    assign m_last_out = state_reg == ST_BAD || idx_reg == n - 7'd1;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd.take   = s_valid && s_ready;
        cmd.clear  = 1'b0;
        cmd.emit   = state_reg == ST_OUT;
        cmd.idx    = idx_reg;
        case (state_reg)
            ST_IN:   if (s_valid && s_last_byte) state_next = ST_EVAL;
            ST_EVAL: begin
                idx_next = '0;
                state_next = (sts.ok && q != 7'd0) ? ST_OUT : ST_BAD;
            end
            ST_OUT: if (m_ready) begin
                idx_next = idx_reg + 7'd1;
                if (idx_reg == n - 7'd1) begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IN;
                end
            end
            ST_BAD: if (m_ready) begin
                cmd.clear  = 1'b1;
                state_next = ST_IN;
            end
            default: state_next = ST_IN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IN;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    `ASSERT_IMPLIES(a_no_take_busy, aclk, aresetn, state_reg != ST_IN, !cmd.take)
    `ASSERT_IMPLIES(a_idx_range, aclk, aresetn, state_reg == ST_OUT, idx_reg < n)
    `ASSERT_NEXT(a_bad_single, aclk, aresetn, state_reg == ST_BAD && m_ready,
                 state_reg == ST_IN)
endmodule
`default_nettype wire

/* rtl/der_signature_to_raw_scalars_unit.sv */
// Top level: DER signature bytes in, raw r and s bytes out.
// Depends on dsig_pkg. One byte accepted per cycle; input stalls from the final
// byte through evaluation and a burst of 2*min(scalar_bytes, MAX_SCALAR_BYTES)
// results (or one malformed result), sent one per cycle while m_ready is high.
// Synchronous active-low reset returns parse state to start and scalar_bytes to 32.
`default_nettype none
module der_signature_to_raw_scalars_unit #(
    parameter int MAX_SCALAR_BYTES = 32,
    parameter int LENGTH_BITS      = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [5:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_sig_byte,
    input  wire logic       s_last_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_status,
    output logic            m_last_out
);
    logic [5:0] sb_reg;
    logic [6:0] q;
    logic [7:0] byte_w;
    dsig_pkg::dsig_cmd_t cmd;
    dsig_pkg::dsig_sts_t sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) sb_reg <= 6'd32;
        else if (cfg_we) sb_reg <= cfg_wdata;
    end

    assign q = (7'(sb_reg) > 7'(MAX_SCALAR_BYTES)) ? 7'(MAX_SCALAR_BYTES) : 7'(sb_reg);

    dsig_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_last_byte(s_last_byte),
        .s_ready(s_ready), .m_ready(m_ready), .m_valid(m_valid), .m_status(m_status),
        .m_last_out(m_last_out), .q(q), .sts(sts), .cmd(cmd)
    );

    dsig_datapath #(.MAX_SCALAR_BYTES(MAX_SCALAR_BYTES), .LENGTH_BITS(LENGTH_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .sig_byte(s_sig_byte), .cmd(cmd), .q(q),
        .sts(sts), .out_byte(byte_w)
    );

    assign m_out_byte = (cmd.emit && !m_status) ? byte_w : 8'd0;
endmodule
`default_nettype wire
